// ----- design/rbst_pkg.sv -----
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared widths, codes, types and the saturation helper of the ray versus
// box slab test.
// ----------------------------------------------------------------------------
package rbst_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  localparam int DIV_W  = 2 * FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(DIV_W + 1);
  localparam int REM_W  = COORD_WIDTH + 1;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = DIFF_W + COORD_WIDTH;
  localparam int SAT_W  = (PROD_W > DIV_W) ? PROD_W : DIV_W;
  localparam int NUM_AXES = 3;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TEST = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIV_END,
    ST_MUL,
    ST_SAT,
    ST_MERGE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic div_end;
    logic test;
    logic mul;
    logic sat;
  } lane_ctl_t;

  typedef struct packed {
    coord_t t_enter;
    coord_t t_exit;
    logic   flat;
    logic   in_slab;
  } lane_res_t;

  function automatic coord_t sat_signed(input logic neg, input logic [SAT_W-1:0] mag);
    logic [SAT_W-1:0] lim_pos;
    logic [SAT_W-1:0] lim_neg;
    logic [SAT_W-1:0] negated;
    coord_t r;
    lim_pos = {{(SAT_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    lim_neg = lim_pos + 1'b1;
    negated = ~mag + 1'b1;
    if (!neg) begin
      r = (mag > lim_pos) ? lim_pos[COORD_WIDTH-1:0] : mag[COORD_WIDTH-1:0];
    end else begin
      r = (mag > lim_neg) ? {1'b1, {(COORD_WIDTH-1){1'b0}}} : negated[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/rbst_lane.sv -----
// ----------------------------------------------------------------------------
// rbst_lane
// One axis of the slab test: holds the ray origin and reciprocal of its axis,
// computes the reciprocal with a restoring divider, and turns a box slab into
// saturated entry and exit distances.
// ----------------------------------------------------------------------------
module rbst_lane
  import rbst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  lane_ctl_t ctl,
  input  coord_t    va,
  input  coord_t    vb,
  output lane_res_t res
);

  coord_t                  origin;
  coord_t                  inv;
  logic [COORD_WIDTH-1:0]  inv_mag;
  logic                    flat;

  logic [REM_W-1:0]        rem;
  logic [DIV_W-1:0]        dvd;
  logic [DIV_W-1:0]        quo;
  logic [COORD_WIDTH-1:0]  dmag;
  logic                    dneg;

  logic [DIFF_W-1:0]       mag0;
  logic [DIFF_W-1:0]       mag1;
  logic                    neg0;
  logic                    neg1;
  logic [PROD_W-1:0]       prod0;
  logic [PROD_W-1:0]       prod1;

  logic [REM_W-1:0]        rem_sh;
  logic signed [DIFF_W-1:0] diff0;
  logic signed [DIFF_W-1:0] diff1;
  coord_t                  inv_next;
  coord_t                  t0;
  coord_t                  t1;
  logic [PROD_W-1:0]       sh0;
  logic [PROD_W-1:0]       sh1;

  assign rem_sh = {rem[REM_W-2:0], dvd[DIV_W-1]};
  assign diff0  = {va[COORD_WIDTH-1], va} - {origin[COORD_WIDTH-1], origin};
  assign diff1  = {vb[COORD_WIDTH-1], vb} - {origin[COORD_WIDTH-1], origin};
  assign inv_next = flat ? '0 : sat_signed(dneg && (quo != '0), SAT_W'(quo));
  assign sh0 = prod0 >> FRAC_BITS;
  assign sh1 = prod1 >> FRAC_BITS;
  assign t0  = sat_signed(neg0, SAT_W'(sh0));
  assign t1  = sat_signed(neg1, SAT_W'(sh1));

  always_ff @(posedge clk) begin
    if (rst) begin
      origin  <= '0;
      inv     <= '0;
      inv_mag <= '0;
      flat    <= 1'b0;
    end else begin
      if (ctl.load) begin
        origin <= va;
        flat   <= (vb == '0);
      end
      if (ctl.div_end) begin
        inv     <= inv_next;
        inv_mag <= inv_next[COORD_WIDTH-1] ? (~inv_next + 1'b1) : inv_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dmag <= vb[COORD_WIDTH-1] ? (~vb + 1'b1) : vb;
      dneg <= vb[COORD_WIDTH-1];
      rem  <= '0;
      dvd  <= {1'b1, {(DIV_W-1){1'b0}}};
      quo  <= '0;
    end else if (ctl.div_step) begin
      dvd <= {dvd[DIV_W-2:0], 1'b0};
      if (rem_sh >= REM_W'(dmag)) begin
        rem <= rem_sh - REM_W'(dmag);
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
    if (ctl.test) begin
      mag0 <= diff0[DIFF_W-1] ? (~diff0 + 1'b1) : diff0;
      mag1 <= diff1[DIFF_W-1] ? (~diff1 + 1'b1) : diff1;
      neg0 <= diff0[DIFF_W-1] ^ inv[COORD_WIDTH-1];
      neg1 <= diff1[DIFF_W-1] ^ inv[COORD_WIDTH-1];
      res.in_slab <= (origin >= va) && (origin <= vb);
      res.flat    <= flat;
    end
    if (ctl.mul) begin
      prod0 <= PROD_W'(mag0) * PROD_W'(inv_mag);
      prod1 <= PROD_W'(mag1) * PROD_W'(inv_mag);
    end
    if (ctl.sat) begin
      res.t_enter <= inv[COORD_WIDTH-1] ? t1 : t0;
      res.t_exit  <= inv[COORD_WIDTH-1] ? t0 : t1;
    end
  end

endmodule

// ----- design/rbst_merge.sv -----
// ----------------------------------------------------------------------------
// rbst_merge
// Combines the per-axis distances of the lanes with the stored interval and
// decides hit or miss.
// ----------------------------------------------------------------------------
module rbst_merge
  import rbst_pkg::*;
(
  input  lane_res_t lanes [NUM_AXES],
  input  coord_t    start_t,
  input  coord_t    end_t,
  output logic      hit
);

  coord_t lo;
  coord_t hi;
  logic   pass;

  always_comb begin
    lo   = start_t;
    hi   = end_t;
    pass = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (lanes[a].flat) begin
        pass = pass & lanes[a].in_slab;
      end else begin
        if (lanes[a].t_enter > lo) begin
          lo = lanes[a].t_enter;
        end
        if (lanes[a].t_exit < hi) begin
          hi = lanes[a].t_exit;
        end
      end
    end
    hit = pass && (hi > lo);
  end

endmodule

// ----- design/ray_box_slab_test_top.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_test_top
// Ray versus axis-aligned box slab test in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// A load transfer (func 0) stores the ray; no further transfer is accepted
// until the three per-axis reciprocals are done. They come from restoring
// dividers that produce one quotient bit per cycle (2*FRAC_BITS+1 bits),
// with a start step before and a saturate step after. A load gives no
// result. A test transfer (func 1) runs through difference, multiply,
// saturate and swap, and merge steps in three lanes side by side and then
// writes its hit bit into the output register; the next transfer is
// accepted once the merge has delivered, and the merge waits while the
// output register holds an undrained result.
module ray_box_slab_test_top
  import rbst_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   func,
  input  coord_t vec_a_x,
  input  coord_t vec_a_y,
  input  coord_t vec_a_z,
  input  coord_t vec_b_x,
  input  coord_t vec_b_y,
  input  coord_t vec_b_z,
  input  coord_t t_low,
  input  coord_t t_high,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   hit
);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] div_cnt;
  coord_t           interval_start;
  coord_t           interval_end;
  lane_ctl_t        ctl;
  lane_res_t        lanes [NUM_AXES];
  coord_t           va [NUM_AXES];
  coord_t           vb [NUM_AXES];
  logic             merge_hit;
  logic             in_xfer;
  logic             out_free;

  assign va[0] = vec_a_x;
  assign va[1] = vec_a_y;
  assign va[2] = vec_a_z;
  assign vb[0] = vec_b_x;
  assign vb[1] = vec_b_y;
  assign vb[2] = vec_b_z;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (func == FUNC_LOAD) ? ST_DIV : ST_MUL;
        end
      end
      ST_DIV: begin
        if (div_cnt == CNT_W'(DIV_W - 1)) begin
          state_next = ST_DIV_END;
        end
      end
      ST_DIV_END: state_next = ST_IDLE;
      ST_MUL:     state_next = ST_SAT;
      ST_SAT:     state_next = ST_MERGE;
      ST_MERGE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.load     = in_xfer && (func == FUNC_LOAD);
    ctl.test     = in_xfer && (func == FUNC_TEST);
    ctl.div_step = (state == ST_DIV);
    ctl.div_end  = (state == ST_DIV_END);
    ctl.mul      = (state == ST_MUL);
    ctl.sat      = (state == ST_SAT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      div_cnt        <= '0;
      interval_start <= '0;
      interval_end   <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load) begin
        div_cnt        <= '0;
        interval_start <= t_low;
        interval_end   <= t_high;
      end else if (ctl.div_step) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if ((state == ST_MERGE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_MERGE) && out_free) begin
      hit <= merge_hit;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    rbst_lane u_lane (
      .clk (clk),
      .rst (rst),
      .ctl (ctl),
      .va  (va[a]),
      .vb  (vb[a]),
      .res (lanes[a])
    );
  end

  rbst_merge u_merge (
    .lanes   (lanes),
    .start_t (interval_start),
    .end_t   (interval_end),
    .hit     (merge_hit)
  );

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (func == FUNC_LOAD)) |=> (!in_ready && !$rose(out_valid)))
    else $error("load transfer did not occupy the divider");

  a_result_from_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_MERGE))
    else $error("result appeared without a merge");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_END) |-> ($past(div_cnt) == CNT_W'(DIV_W - 1)))
    else $error("divider finished with a wrong step count");

endmodule
